/* rtl/sai_pkg.sv */
// Shared types and constants of the stepper angle indexer.
// No dependencies; every other file of the block imports this package.
package sai_pkg;

    localparam int MODE_W     = 3;
    localparam int IN_ANGLE_W = 15;
    localparam int ANGLE_W    = 14;
    localparam int STEPS_W    = 16;
    localparam int HIGH_W     = 10;
    localparam int LOW_W      = 16;
    localparam int TIMER_W    = 16;
    localparam int POS_W      = 18;
    localparam int COUNT_W    = 17;
    localparam int PROD_W     = ANGLE_W + STEPS_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // |angle * total_steps| < 2^29; divide by 5760 = 128 * 45.
    // Divide by 45 as multiply by ceil(2^28 / 45), exact for 23-bit dividends.
    localparam int DIV_SHIFT   = 7;
    localparam int MAG_W       = 30;
    localparam int DIVIDEND_W  = MAG_W - DIV_SHIFT;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_45 = 23'd5965233;
    localparam int RECIP_PROD_W = DIVIDEND_W + RECIP_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS   = 3'd4;

    // Register reset values (min angle is -2880 in 14-bit two's complement).
    localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST   = 14'd13504;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST   = 14'd2880;
    localparam logic [STEPS_W-1:0] TOTAL_STEPS_RST = 16'd6400;
    localparam logic [HIGH_W-1:0]  HIGH_TICKS_RST  = 10'd1;
    localparam logic [LOW_W-1:0]   LOW_TICKS_RST   = 16'd1000;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ABS  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEC  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd5;

    typedef enum logic [2:0] {
        K_TICK = 3'd0,
        K_ABS  = 3'd1,
        K_INC  = 3'd2,
        K_DEC  = 3'd3,
        K_MIN  = 3'd4,
        K_MAX  = 3'd5,
        K_NOP  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [IN_ANGLE_W-1:0] angle;
    } t_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] max_angle;
        logic [STEPS_W-1:0] total_steps;
        logic [HIGH_W-1:0]  high_ticks;
        logic [LOW_W-1:0]   low_ticks;
    } t_cfg;

endpackage

/* rtl/sai_if.sv */
// Valid/ready channel interfaces of the stepper angle indexer:
// command input, result output and configuration write. Uses sai_pkg.
interface sai_in_if import sai_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [MODE_W-1:0]            mode;
    logic signed [IN_ANGLE_W-1:0] angle;

    modport source (output valid, output mode, output angle, input ready);
    modport sink   (input valid, input mode, input angle, output ready);
endinterface

interface sai_out_if import sai_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      step_level;
    logic                      direction;
    logic signed [COUNT_W-1:0] step_count;
    logic signed [ANGLE_W-1:0] position_angle;
    logic                      busy_res;

    modport source (output valid, output step_level, output direction, output step_count,
                    output position_angle, output busy_res, input ready);
    modport sink   (input valid, input step_level, input direction, input step_count,
                    input position_angle, input busy_res, output ready);
endinterface

interface sai_cfg_if import sai_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sai_regs.sv */
// Configuration registers of the stepper angle indexer.
// Depends on sai_pkg and sai_cfg_if.
module sai_regs import sai_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sai_cfg_if.sink       i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_angle   <= MIN_ANGLE_RST;
            r_cfg.max_angle   <= MAX_ANGLE_RST;
            r_cfg.total_steps <= TOTAL_STEPS_RST;
            r_cfg.high_ticks  <= HIGH_TICKS_RST;
            r_cfg.low_ticks   <= LOW_TICKS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_ANGLE:   r_cfg.min_angle   <= i_cfg.data[ANGLE_W-1:0];
                REG_MAX_ANGLE:   r_cfg.max_angle   <= i_cfg.data[ANGLE_W-1:0];
                REG_TOTAL_STEPS: r_cfg.total_steps <= i_cfg.data[STEPS_W-1:0];
                REG_HIGH_TICKS:  r_cfg.high_ticks  <= i_cfg.data[HIGH_W-1:0];
                REG_LOW_TICKS:   r_cfg.low_ticks   <= i_cfg.data[LOW_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/sai_front.sv */
// Front end: accept input beats, decode the mode and hold them in a short queue.
// Depends on sai_pkg and sai_in_if.
module sai_front import sai_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sai_in_if.sink i_cmd,
    output t_item o_head,
    output logic  o_head_valid,
    input  logic  i_pop
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;
    t_item             item;

    always_comb begin
        item.angle = i_cmd.angle;
        case (i_cmd.mode)
            MODE_TICK: item.kind = K_TICK;
            MODE_ABS:  item.kind = K_ABS;
            MODE_INC:  item.kind = K_INC;
            MODE_DEC:  item.kind = K_DEC;
            MODE_MIN:  item.kind = K_MIN;
            MODE_MAX:  item.kind = K_MAX;
            default:   item.kind = K_NOP;
        endcase
    end

    assign i_cmd.ready  = (r_count != QCNT_W'(QDEPTH));
    assign push         = i_cmd.valid && i_cmd.ready;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/sai_back.sv */
// Back end: execute queued items (pulse timing on ticks, angle and target on
// commands) and hold the result register. Depends on sai_pkg and sai_out_if.
module sai_back import sai_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  t_item  i_head,
    input  logic   i_head_valid,
    output logic   o_pop,
    sai_out_if.source o_res
);

    typedef enum logic [3:0] {
        S_RUN    = 4'b0001,
        S_MUL    = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [ANGLE_W-1:0] r_angle, n_angle;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_target, n_target;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_high, n_high;
    logic               r_dir, n_dir;

    logic signed [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]         r_quot;
    logic                     r_qneg;

    logic                      r_o_valid, n_o_valid;
    logic                      r_o_level, n_o_level;
    logic                      r_o_dir, n_o_dir;
    logic [COUNT_W-1:0]        r_o_count, n_o_count;
    logic [ANGLE_W-1:0]        r_o_angle, n_o_angle;
    logic                      r_o_busy, n_o_busy;

    logic                    can_emit;
    logic                    is_cmd;
    logic signed [15:0]      s_min, s_max, s_cur, s_in, s_sum, s_lim, s_clamp;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]       mag;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [POS_W-1:0]        fin_target;
    logic                    start;
    logic [TIMER_W-1:0]      high_eff, low_eff, cur_timer, dec_timer;
    logic                    cur_high, cur_dir;

    assign can_emit = !r_o_valid || o_res.ready;
    assign is_cmd   = (i_head.kind inside {K_ABS, K_INC, K_DEC, K_MIN, K_MAX});
    assign o_pop    = (r_state == S_RUN) && i_head_valid && (is_cmd || can_emit);

    // New angle: limit the sum for increase/decrease, then clamp to the range.
    always_comb begin
        s_min = {{2{i_cfg.min_angle[ANGLE_W-1]}}, i_cfg.min_angle};
        s_max = {{2{i_cfg.max_angle[ANGLE_W-1]}}, i_cfg.max_angle};
        s_cur = {{2{r_angle[ANGLE_W-1]}}, r_angle};
        s_in  = {i_head.angle[IN_ANGLE_W-1], i_head.angle};
        s_sum = s_cur;
        case (i_head.kind)
            K_ABS: s_lim = s_in;
            K_INC: begin
                s_sum = s_cur + s_in;
                s_lim = (s_sum > s_max) ? s_max : s_sum;
            end
            K_DEC: begin
                s_sum = s_cur - s_in;
                s_lim = (s_sum < s_min) ? s_min : s_sum;
            end
            K_MIN:   s_lim = s_min;
            K_MAX:   s_lim = s_max;
            default: s_lim = s_cur;
        endcase
        if (s_lim < s_min) begin
            s_clamp = s_min;
        end else if (s_lim > s_max) begin
            s_clamp = s_max;
        end else begin
            s_clamp = s_lim;
        end
    end

    // Scale: angle * total_steps, then divide magnitude by 5760.
    assign prod       = $signed(r_angle) * $signed({1'b0, i_cfg.total_steps});
    assign mag        = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign recip_prod = RECIP_PROD_W'(mag[MAG_W-1:DIV_SHIFT]) * RECIP_PROD_W'(RECIP_45);
    assign fin_target = r_qneg ? (~r_quot + 1'b1) : r_quot;

    // Tick timing.
    assign high_eff  = (i_cfg.high_ticks == '0) ? TIMER_W'(1) : TIMER_W'(i_cfg.high_ticks);
    assign low_eff   = (i_cfg.low_ticks == '0) ? TIMER_W'(1) : TIMER_W'(i_cfg.low_ticks);
    assign start     = !r_high && (r_timer == '0) && (r_pos != r_target);
    assign cur_high  = start ? 1'b1 : r_high;
    assign cur_dir   = start ? ($signed(r_target) > $signed(r_pos)) : r_dir;
    assign cur_timer = start ? high_eff : r_timer;
    assign dec_timer = cur_timer - 1'b1;

    always_comb begin
        n_state   = r_state;
        n_angle   = r_angle;
        n_pos     = r_pos;
        n_target  = r_target;
        n_timer   = r_timer;
        n_high    = r_high;
        n_dir     = r_dir;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_level = r_o_level;
        n_o_dir   = r_o_dir;
        n_o_count = r_o_count;
        n_o_angle = r_o_angle;
        n_o_busy  = r_o_busy;
        case (r_state)
            S_RUN: begin
                if (o_pop) begin
                    if (is_cmd) begin
                        n_angle = s_clamp[ANGLE_W-1:0];
                        n_state = S_MUL;
                    end else begin
                        if (i_head.kind == K_TICK) begin
                            n_high  = cur_high;
                            n_dir   = cur_dir;
                            n_timer = cur_timer;
                            if (cur_timer != '0) begin
                                n_timer = dec_timer;
                                if (dec_timer == '0) begin
                                    if (cur_high) begin
                                        n_high  = 1'b0;
                                        n_timer = low_eff;
                                    end else begin
                                        n_pos = cur_dir ? r_pos + 1'b1 : r_pos - 1'b1;
                                    end
                                end
                            end
                        end
                        n_o_valid = 1'b1;
                        n_o_level = (i_head.kind == K_TICK) ? cur_high : r_high;
                        n_o_dir   = (i_head.kind == K_TICK) ? cur_dir : r_dir;
                        n_o_count = n_pos[COUNT_W-1:0];
                        n_o_angle = r_angle;
                        n_o_busy  = n_high || (n_timer != '0) || (n_pos != r_target);
                    end
                end
            end
            S_MUL:    n_state = S_DIV;
            S_DIV:    n_state = S_FINISH;
            S_FINISH: begin
                if (can_emit) begin
                    n_target  = fin_target;
                    n_o_valid = 1'b1;
                    n_o_level = r_high;
                    n_o_dir   = r_dir;
                    n_o_count = r_pos[COUNT_W-1:0];
                    n_o_angle = r_angle;
                    n_o_busy  = r_high || (r_timer != '0) || (r_pos != fin_target);
                    n_state   = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= prod;
        end
        if (r_state == S_DIV) begin
            r_quot <= recip_prod[RECIP_SHIFT+POS_W-1:RECIP_SHIFT];
            r_qneg <= r_prod[PROD_W-1];
        end
        r_o_level <= n_o_level;
        r_o_dir   <= n_o_dir;
        r_o_count <= n_o_count;
        r_o_angle <= n_o_angle;
        r_o_busy  <= n_o_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_angle   <= MIN_ANGLE_RST;
            r_pos     <= '0;
            r_target  <= '0;
            r_timer   <= '0;
            r_high    <= 1'b0;
            r_dir     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_angle   <= n_angle;
            r_pos     <= n_pos;
            r_target  <= n_target;
            r_timer   <= n_timer;
            r_high    <= n_high;
            r_dir     <= n_dir;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.step_level     = r_o_level;
    assign o_res.direction      = r_o_dir;
    assign o_res.step_count     = r_o_count;
    assign o_res.position_angle = r_o_angle;
    assign o_res.busy_res       = r_o_busy;

endmodule

/* rtl/stepper_angle_indexer_unit.sv */
// Top level of the stepper angle indexer: configuration registers, front-end
// queue and back-end executor. Depends on sai_pkg, sai_if, sai_regs,
// sai_front and sai_back.
//
// Usage:
//  - i_cfg writes one of five registers (min/max angle, total steps, high and
//    low tick counts); it is always ready. Write only while the block is idle.
//  - i_cmd takes one beat per item: mode 0 is a 1 us tick, modes 1..5 are
//    angle commands, modes 6 and 7 change nothing.
//  - o_res gives exactly one beat per input beat, in order: step line level,
//    direction, step count, clamped angle and busy flag.
// Queue and executor:
//  - A beat lands in a 4-entry queue and is registered there before the executor
//    takes it; a tick's result loads straight from the queue head, a command's
//    result only after the multiply, divide and finish states.
//  - Ticks and unused modes leave the queue at one per cycle unless o_res stalls.
//  - A command holds the executor while it steps through clamp, multiply by total
//    steps, divide by 5760 through a reciprocal multiply, then retarget.
//  - Input stays ready while the queue has room, even when a result waits.
// Reset: registers take their defaults, the angle is the min angle, count
//  and target are 0, the step line is low and the queue and result are empty.
// Stall: when o_res is held off the result stays put, the executor stops at its
//  next result and the queue fills; i_cmd drops ready once four beats are waiting.
module stepper_angle_indexer_unit import sai_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sai_cfg_if.sink    i_cfg,
    sai_in_if.sink     i_cmd,
    sai_out_if.source  o_res
);

    t_cfg  cfg;
    t_item head;
    logic  head_valid;
    logic  pop;

    // Configuration registers.
    sai_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Accept and decode beats, hold them until the executor takes them.
    sai_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    // Execute items and drive the result channel.
    sai_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

/* bench/stepper_angle_indexer_unit_tb.sv */
// Self-checking bench for stepper_angle_indexer_unit: directed and random beats against a
// cycle-free predictor of angle clamping, retargeting and step pulse timing.
// Depends on sai_pkg, the sai_if channel interfaces and the unit itself.
module stepper_angle_indexer_unit_tb;
    import sai_pkg::*;

    // Modes 6 and 7 have no code in the package; the unit ignores both.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int ANGLE_PER_REV = 5760;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;

    // One result beat as the predictor expects it.
    typedef struct {
        logic                      level;
        logic                      dir;
        logic signed [COUNT_W-1:0] count;
        logic signed [ANGLE_W-1:0] angle;
        logic                      busy;
    } t_drive;

    logic clk = 1'b0;
    logic rst_n;

    sai_in_if  cmd_bus ();
    sai_out_if res_bus ();
    sai_cfg_if cfg_bus ();

    stepper_angle_indexer_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the registers.
    int lim_lo, lim_hi, steps_rev, hi_ticks, lo_ticks;
    // Predictor copy of the indexer state.
    int ang_cmd, pos_now, pos_goal, pulse_timer;
    logic line_high, line_dir;

    t_drive drive_due[$];
    int     fail_count = 0;

    // Idling knobs, set by the stimulus process; stall_phase and idle_cycles are kept by the receiver and the watchdog.
    logic        gap_on;
    logic        stall_on;
    logic [15:0] stall_mask;
    int          burst_left;
    logic [3:0]  stall_phase = '0;
    int          idle_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Store a clamped angle and derive the step target, truncated toward zero.
    function automatic void retarget(input int raw);
        longint prod;
        if (raw < lim_lo) ang_cmd = lim_lo;
        else if (raw > lim_hi) ang_cmd = lim_hi;
        else ang_cmd = raw;
        prod     = longint'(ang_cmd) * longint'(steps_rev);
        pos_goal = int'(prod / ANGLE_PER_REV);
    endfunction

    // Advance the indexer by one input beat and return the result it owes.
    function automatic t_drive advance_indexer(input logic [MODE_W-1:0] mode,
                                               input logic signed [IN_ANGLE_W-1:0] amount);
        t_drive r;
        int     a;
        int     sum;
        a       = amount;
        r.level = line_high;
        r.dir   = line_dir;
        case (mode)
            MODE_TICK: begin
                // Start a pulse only from rest with steps left to go.
                if (!line_high && pulse_timer == 0 && pos_now != pos_goal) begin
                    line_dir    = pos_goal > pos_now;
                    line_high   = 1'b1;
                    pulse_timer = (hi_ticks != 0) ? hi_ticks : 1;
                end
                r.level = line_high;
                r.dir   = line_dir;
                if (pulse_timer > 0) begin
                    pulse_timer--;
                    if (pulse_timer == 0) begin
                        if (line_high) begin
                            line_high   = 1'b0;
                            pulse_timer = (lo_ticks != 0) ? lo_ticks : 1;
                        end else begin
                            pos_now += line_dir ? 1 : -1;
                        end
                    end
                end
            end
            MODE_ABS: retarget(a);
            MODE_INC: begin
                sum = ang_cmd + a;
                if (sum > lim_hi) sum = lim_hi;
                retarget(sum);
            end
            MODE_DEC: begin
                sum = ang_cmd - a;
                if (sum < lim_lo) sum = lim_lo;
                retarget(sum);
            end
            MODE_MIN: retarget(lim_lo);
            MODE_MAX: retarget(lim_hi);
            default: ;
        endcase
        r.count = COUNT_W'(pos_now);
        r.angle = ANGLE_W'(ang_cmd);
        r.busy  = line_high || pulse_timer != 0 || pos_now != pos_goal;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic signed [COUNT_W-1:0] want,
                               input logic signed [COUNT_W-1:0] got);
        if (got !== want)
            log_failure($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk) begin : check_results
        t_drive want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (drive_due.size() == 0) begin
                log_failure("result beat with no item pending");
            end else begin
                want = drive_due.pop_front();
                check_field("step_level", want.level, res_bus.step_level);
                check_field("direction", want.dir, res_bus.direction);
                check_field("step_count", want.count, res_bus.step_count);
                check_field("position_angle", want.angle, res_bus.position_angle);
                check_field("busy_res", want.busy, res_bus.busy_res);
            end
        end
    end

    // Receiver: hold off on a rotating 16-bit mask, or take every beat.
    always @(negedge clk) begin
        res_bus.ready <= !stall_on || stall_mask[stall_phase];
        stall_phase   <= stall_phase + 4'd1;
    end

    // Watchdog: end the run if no channel moves a beat for too long.
    always @(posedge clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("stepper_angle_indexer_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one command beat; open a new burst after a random gap when idling is on.
    task automatic send_item(input logic [MODE_W-1:0] mode, input int amount);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = gap_on ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                @(negedge clk) cmd_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        cmd_bus.valid <= 1'b1;
        cmd_bus.mode  <= mode;
        cmd_bus.angle <= IN_ANGLE_W'(amount);
        do @(posedge clk); while (!cmd_bus.ready);
        drive_due.push_back(advance_indexer(mode, IN_ANGLE_W'(amount)));
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic drain_results();
        @(negedge clk) cmd_bus.valid <= 1'b0;
        burst_left = 0;
        while (drive_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic signed [ANGLE_W-1:0] a14;
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_bus.ready);
        a14 = value[ANGLE_W-1:0];
        case (idx)
            REG_MIN_ANGLE:   lim_lo    = a14;
            REG_MAX_ANGLE:   lim_hi    = a14;
            REG_TOTAL_STEPS: steps_rev = value & 16'hFFFF;
            REG_HIGH_TICKS:  hi_ticks  = value & 10'h3FF;
            REG_LOW_TICKS:   lo_ticks  = value & 16'hFFFF;
            default: ;
        endcase
        @(negedge clk) cfg_bus.valid <= 1'b0;
    endtask

    // Reprogram all five registers once the unit is idle.
    task automatic load_setting(input int lo, input int hi, input int steps,
                                input int high_t, input int low_t);
        drain_results();
        write_reg(REG_MIN_ANGLE, lo);
        write_reg(REG_MAX_ANGLE, hi);
        write_reg(REG_TOTAL_STEPS, steps);
        write_reg(REG_HIGH_TICKS, high_t);
        write_reg(REG_LOW_TICKS, low_t);
        stall_mask = 16'($urandom) | 16'h0001;
    endtask

    // Mostly ticks so moves run to completion; commands land mid-move at random.
    // Pause for a full drain at pause_at, if it is within the run.
    task automatic run_random_items(input int n, input int tick_pct, input int span,
                                    input int pause_at);
        logic [MODE_W-1:0] cmd_modes[5];
        logic [MODE_W-1:0] mode;
        int                pick;
        int                amount;
        cmd_modes = '{MODE_ABS, MODE_INC, MODE_DEC, MODE_MIN, MODE_MAX};
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) mode = MODE_TICK;
            else if (pick >= 98) mode = pick[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
            else mode = cmd_modes[$urandom_range(0, 4)];
            // Mostly amounts near the limits, sometimes the whole field.
            if ($urandom_range(0, 99) < 15) amount = $urandom;
            else amount = int'($urandom_range(0, 2 * span)) - span;
            send_item(mode, amount);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Angle sits at the min limit while count and target are 0: nothing moves.
    task automatic test_reset_defaults();
        repeat (3) send_item(MODE_TICK, 0);
        send_item(MODE_SPARE_LO, 16383);
        send_item(MODE_SPARE_HI, -16384);
    endtask

    // Every mode with the extremes of the angle field, then a pulse start.
    task automatic test_directed_modes();
        send_item(MODE_ABS, 16383);
        send_item(MODE_ABS, -16384);
        send_item(MODE_ABS, 0);
        send_item(MODE_INC, 16383);
        send_item(MODE_INC, -16384);
        send_item(MODE_INC, 1);
        send_item(MODE_DEC, 16383);
        send_item(MODE_DEC, -16384);
        send_item(MODE_MIN, 0);
        send_item(MODE_MAX, 0);
        repeat (4) send_item(MODE_TICK, 0);
        // Retarget while the first pulse is still in its low phase.
        send_item(MODE_ABS, -1);
        send_item(MODE_TICK, 0);
    endtask

    // Two-tick steps over a narrow range: moves finish and reverse often.
    task automatic test_fast_stepping();
        gap_on   = 1'b1;
        stall_on = 1'b1;
        load_setting(-48, 48, ANGLE_PER_REV, 1, 1);
        run_random_items(250, 85, 60, -1);
    endtask

    // Min above max: low values pin to min, all others to max.
    task automatic test_crossed_limits();
        load_setting(150, -150, 3000, 2, 3);
        run_random_items(180, 80, 300, -1);
    endtask

    // Zero tick counts act as one tick each.
    task automatic test_zero_tick_counts();
        load_setting(-300, 300, 200, 0, 0);
        run_random_items(180, 85, 400, -1);
    endtask

    // Widest limits with the largest and smallest step and tick counts.
    task automatic test_extreme_settings();
        load_setting(-5760, 5760, 65535, 1023, 65535);
        run_random_items(60, 50, 8000, -1);
        load_setting(-5760, 5760, 1, 1, 1);
        run_random_items(100, 70, 8000, -1);
    endtask

    // Full-rate beats in both directions with no gaps and no stalls.
    task automatic test_no_idling();
        load_setting(-100, 100, 1440, 1, 2);
        gap_on   = 1'b0;
        stall_on = 1'b0;
        run_random_items(230, 85, 150, -1);
        gap_on   = 1'b1;
        stall_on = 1'b1;
    endtask

    // Random moderate settings; each round holds the sender once until drained.
    task automatic test_random_settings();
        int span;
        for (int round = 0; round < 3; round++) begin
            span = $urandom_range(20, 600);
            load_setting(-int'($urandom_range(0, span)), $urandom_range(0, span),
                         $urandom_range(1, 1200), $urandom_range(1, 4),
                         $urandom_range(1, 6));
            run_random_items(130, 80, span + 50, 65);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.mode  = MODE_TICK;
        cmd_bus.angle = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_MIN_ANGLE;
        cfg_bus.data  = '0;
        res_bus.ready = 1'b0;
        gap_on        = 1'b1;
        stall_on      = 1'b1;
        stall_mask    = 16'($urandom) | 16'h0001;
        burst_left    = 0;

        // Register defaults and reset state of the predictor.
        lim_lo      = -2880;
        lim_hi      = 2880;
        steps_rev   = 6400;
        hi_ticks    = 1;
        lo_ticks    = 1000;
        ang_cmd     = -2880;
        pos_now     = 0;
        pos_goal    = 0;
        pulse_timer = 0;
        line_high   = 1'b0;
        line_dir    = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        test_reset_defaults();
        test_directed_modes();
        test_fast_stepping();
        test_crossed_limits();
        test_zero_tick_counts();
        test_extreme_settings();
        test_no_idling();
        test_random_settings();

        // Settle: wait out every owed beat, then watch for strays.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (drive_due.size() != 0) log_failure("predicted beats left over");
        if (fail_count == 0) begin
            $display("stepper_angle_indexer_unit_tb OK");
        end else begin
            $display("stepper_angle_indexer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
